// ----- sv/ufp_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the uart fifo peripheral
// no dependencies; imported by ufp_ring and uart_fifo_peripheral_top
package ufp_pkg;

	// tx and rx fifo geometry
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// line holding buffer geometry
	localparam int HOLD_DEPTH = 16;
	localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [15:0] CPC_RESET = 16'd100;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_LINE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_DATA   = 2'd0,
		REG_CTRL   = 2'd1,
		REG_STATUS = 2'd2,
		REG_UNUSED = 2'd3
	} reg_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UART_EN = 3'd0,
		CFG_RX_EN   = 3'd1,
		CFG_TX_EN   = 3'd2,
		CFG_TXE_IRQ = 3'd3,
		CFG_RXR_IRQ = 3'd4,
		CFG_CPC     = 3'd5
	} cfg_reg_t;

	// ring buffer control and status
	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic one_left;
	} ring_stat_t;

endpackage

// ----- sv/uart_fifo_peripheral_top.sv -----
`timescale 1ns / 1ps
// uart peripheral: tx/rx fifos, line holding buffer, tick counter, bus registers
// depends on ufp_pkg and ufp_ring
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ---------------------------------------------
// in       sink       in_valid / in_stall  mode, reg_index, write_data, line_char
// out      source     out_valid / out_stall read_data, tx_char, tx_valid, irq_pulse,
//                                          line_dropped
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one beat in and one beat out per clock when neither side stalls
// a beat is held in the input register, where all fifo, counter and flag updates happen,
// then moves to the output register, from which it is offered
// the fifo/flag update loop within the input stage sets the rate
// arst_n clears all control state; fifo storage is not cleared
// out_stall holds the output register and backs up into in_stall only once both
// stages are full
module uart_fifo_peripheral_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// item channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        mode,
	input  logic [1:0]                        reg_index,
	input  logic [31:0]                       write_data,
	input  logic [7:0]                        line_char,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [31:0]                       read_data,
	output logic [7:0]                        tx_char,
	output logic                              tx_valid,
	output logic                              irq_pulse,
	output logic                              line_dropped,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ufp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ufp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ufp_pkg::*;

	// configuration registers
	logic        uart_en_q;
	logic        rx_en_q;
	logic        tx_en_q;
	logic        txe_irq_en_q;
	logic        rxr_irq_en_q;
	logic [15:0] cpc_q;

	// input stage
	logic        v_s1;
	mode_t       mode_s1;
	reg_sel_t    reg_s1;
	logic [7:0]  wbyte_s1;
	logic [7:0]  lchar_s1;

	// output stage
	logic        v_s2;
	logic [31:0] read_data_s2;
	logic [7:0]  tx_char_s2;
	logic        tx_valid_s2;
	logic        irq_s2;
	logic        dropped_s2;

	// block state
	logic [15:0]        tick_q;
	logic               tx_ovr_q;
	logic               rx_ovr_q;
	logic [7:0]         hold_mem [HOLD_DEPTH];
	logic [HOLD_AW-1:0] hold_rd_q;
	logic [HOLD_AW-1:0] hold_wr_q;
	logic [HOLD_CW-1:0] hold_cnt_q;

	// ring interfaces
	ring_ctl_t  tx_ctl, rx_ctl;
	ring_stat_t tx_stat, rx_stat;
	logic [7:0] tx_pop_data, rx_pop_data;

	// datapath decode
	logic        adv;
	logic        accept;
	logic        is_tick, is_read, is_write, is_line;
	logic        data_sel;
	logic [15:0] tick_inc;
	logic [15:0] period;
	logic        char_time;
	logic        tx_pop, tx_push, tx_ovr_set;
	logic        rx_pop, rx_push, rx_ovr_set;
	logic        hold_empty, hold_full;
	logic        hold_pop, hold_push;
	logic        line_ok, dropped;
	logic        irq;
	logic [31:0] rdata;

	assign cfg_ready = 1'b1;

	// the input stage drains whenever the output register is free or being taken
	assign adv      = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	assign is_tick  = (mode_s1 == MODE_TICK);
	assign is_read  = (mode_s1 == MODE_READ);
	assign is_write = (mode_s1 == MODE_WRITE);
	assign is_line  = (mode_s1 == MODE_LINE);
	assign data_sel = (reg_s1 == REG_DATA);

	// character time: a zero period behaves as one, a counter past a lowered
	// period fires on the next tick
	assign tick_inc  = tick_q + 16'd1;
	assign period    = (cpc_q == '0) ? 16'd1 : cpc_q;
	assign char_time = is_tick && uart_en_q && (tick_inc >= period);

	assign hold_empty = (hold_cnt_q == '0);
	assign hold_full  = (hold_cnt_q == HOLD_CW'(HOLD_DEPTH));

	// transmit side
	assign tx_pop     = char_time && !tx_stat.empty;
	assign tx_push    = is_write && data_sel && !tx_stat.full;
	assign tx_ovr_set = is_write && data_sel && tx_stat.full;

	// receive side: one held character moves per character time
	assign hold_pop   = char_time && !hold_empty;
	assign rx_push    = hold_pop && !rx_stat.full;
	assign rx_ovr_set = hold_pop && rx_stat.full;
	assign rx_pop     = is_read && data_sel && !rx_stat.empty;

	// line input into the holding buffer
	assign line_ok   = is_line && uart_en_q && rx_en_q;
	assign hold_push = line_ok && !hold_full;
	assign dropped   = line_ok && hold_full;

	// tx drained to empty, or rx went non-empty
	assign irq = (tx_pop && tx_stat.one_left && txe_irq_en_q)
		|| (rx_push && rx_stat.empty && rxr_irq_en_q);

	assign tx_ctl.push = adv && tx_push;
	assign tx_ctl.pop  = adv && tx_pop;
	assign rx_ctl.push = adv && rx_push;
	assign rx_ctl.pop  = adv && rx_pop;

	ufp_ring u_tx_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tx_ctl),
		.push_data (wbyte_s1),
		.pop_data  (tx_pop_data),
		.stat      (tx_stat)
	);

	ufp_ring u_rx_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rx_ctl),
		.push_data (hold_mem[hold_rd_q]),
		.pop_data  (rx_pop_data),
		.stat      (rx_stat)
	);

	// bus read mux
	always_comb begin
		rdata = '0;
		if (is_read) begin
			case (reg_s1)
				REG_DATA: begin
					if (!rx_stat.empty) begin
						rdata = {24'd0, rx_pop_data};
					end
				end
				REG_CTRL: begin
					rdata = {cpc_q, 11'd0, rxr_irq_en_q, txe_irq_en_q,
						tx_en_q, rx_en_q, uart_en_q};
				end
				REG_STATUS: begin
					rdata = {27'd0, rx_ovr_q, !rx_stat.empty, tx_ovr_q,
						tx_stat.full, tx_stat.empty};
				end
				default: rdata = '0;
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uart_en_q    <= 1'b0;
			rx_en_q      <= 1'b0;
			tx_en_q      <= 1'b0;
			txe_irq_en_q <= 1'b0;
			rxr_irq_en_q <= 1'b0;
			cpc_q        <= CPC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_UART_EN: uart_en_q    <= cfg_data[0];
				CFG_RX_EN:   rx_en_q      <= cfg_data[0];
				CFG_TX_EN:   tx_en_q      <= cfg_data[0];
				CFG_TXE_IRQ: txe_irq_en_q <= cfg_data[0];
				CFG_RXR_IRQ: rxr_irq_en_q <= cfg_data[0];
				CFG_CPC:     cpc_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode_t'(mode);
			reg_s1   <= reg_sel_t'(reg_index);
			wbyte_s1 <= write_data[7:0];
			lchar_s1 <= line_char;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_s2 <= rdata;
			tx_char_s2   <= (tx_pop && tx_en_q) ? tx_pop_data : 8'd0;
			tx_valid_s2  <= tx_pop && tx_en_q;
			irq_s2       <= irq;
			dropped_s2   <= dropped;
		end
	end

	// holding buffer storage
	always_ff @(posedge clk) begin
		if (adv && hold_push) begin
			hold_mem[hold_wr_q] <= lchar_s1;
		end
	end

	// stage valids, counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			tick_q     <= '0;
			tx_ovr_q   <= 1'b0;
			rx_ovr_q   <= 1'b0;
			hold_rd_q  <= '0;
			hold_wr_q  <= '0;
			hold_cnt_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end

			if (adv) begin
				v_s2 <= 1'b1;
			end else if (!out_stall) begin
				v_s2 <= 1'b0;
			end

			if (adv) begin
				if (is_tick && uart_en_q) begin
					tick_q <= char_time ? 16'd0 : tick_inc;
				end
				if (tx_ovr_set) begin
					tx_ovr_q <= 1'b1;
				end else if (tx_pop) begin
					tx_ovr_q <= 1'b0;
				end
				if (rx_ovr_set) begin
					rx_ovr_q <= 1'b1;
				end else if (rx_pop) begin
					rx_ovr_q <= 1'b0;
				end
				if (hold_push) begin
					hold_wr_q <= (hold_wr_q == HOLD_AW'(HOLD_DEPTH - 1)) ? '0
						: hold_wr_q + 1'b1;
					hold_cnt_q <= hold_cnt_q + 1'b1;
				end else if (hold_pop) begin
					hold_rd_q <= (hold_rd_q == HOLD_AW'(HOLD_DEPTH - 1)) ? '0
						: hold_rd_q + 1'b1;
					hold_cnt_q <= hold_cnt_q - 1'b1;
				end
			end
		end
	end

	assign out_valid    = v_s2;
	assign read_data    = read_data_s2;
	assign tx_char      = tx_char_s2;
	assign tx_valid     = tx_valid_s2;
	assign irq_pulse    = irq_s2;
	assign line_dropped = dropped_s2;

`ifndef SYNTHESIS
	a_tick_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && char_time) |=> (tick_q == 16'd0))
		else $error("tick counter not restarted after character time");
	a_irq_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && irq_s2) |-> (txe_irq_en_q || rxr_irq_en_q))
		else $error("interrupt with both enables clear");
	a_tx_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && tx_valid_s2) |-> tx_en_q)
		else $error("character sent with transmit disabled");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && dropped_s2) |-> hold_full)
		else $error("line character dropped with room in holding buffer");
`endif

endmodule

// ----- sv/ufp_ring.sv -----
`timescale 1ns / 1ps
// circular byte fifo of FIFO_DEPTH entries with occupancy count
// depends on ufp_pkg
module ufp_ring (
	input  logic               clk,
	input  logic               arst_n,
	input  ufp_pkg::ring_ctl_t ctl,
	input  logic [7:0]         push_data,
	output logic [7:0]         pop_data,
	output ufp_pkg::ring_stat_t stat
);
	import ufp_pkg::*;

	logic [7:0]         mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign pop_data       = mem[rd_ptr_q];
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.one_left  = (count_q == FIFO_CW'(1));

	// storage, no reset
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({ctl.push, ctl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (!stat.full || ctl.pop))
		else $error("push into full ring");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !stat.empty)
		else $error("pop from empty ring");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push && !ctl.pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("ring count did not follow push");
`endif

endmodule
